// ===== rtl/dled_pkg.sv =====
package dled_pkg;

  // Actuators per direction
  localparam int MAX_ACTUATORS = 4;
  localparam int CNT_W         = 3;
  localparam int SLOT_W        = 2;
  localparam int RATE_W        = 16;

  // Q1.15 full scale and divider length
  localparam int          FRAC_W    = 16;
  localparam int          DIV_STEPS = 15;
  localparam int          STEP_W    = $clog2(DIV_STEPS);
  localparam logic [15:0] Q15_ONE   = 16'h8000;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RANGE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_OFFSET  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LENGTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_RATES    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_RATES    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_COUNTS   = 4'd7;

  // Input operations
  localparam logic OP_MEAS = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds and directions
  localparam logic KIND_STATE = 1'b0;
  localparam logic KIND_DRIVE = 1'b1;
  localparam logic DIR_INC    = 1'b0;
  localparam logic DIR_DEC    = 1'b1;

  typedef enum logic [1:0] {
    ST_UNDEF = 2'd0,
    ST_BAL   = 2'd1,
    ST_LOW   = 2'd2,
    ST_HIGH  = 2'd3
  } bal_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] measured_value;
  } in_t;

  typedef struct packed {
    logic              kind;
    bal_t              balance_state;
    logic [SLOT_W-1:0] actuator_slot;
    logic              direction;
    logic [15:0]       drive_level;
    logic              last;
  } out_t;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic [30:0]        target_range;
    logic [30:0]        edge_offset;
    logic [30:0]        edge_length;
    logic               enabled;
    logic [63:0]        increase_rates;
    logic [63:0]        decrease_rates;
    logic [5:0]         actuator_counts;
  } cfg_t;

  // Work handed from front to back
  typedef struct packed {
    logic               kind;
    bal_t               state;
    logic signed [31:0] meas;
  } cmd_t;

  // Saturate an actuator count field
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_ACTUATORS);
    return (c > lim) ? lim : c;
  endfunction

endpackage

// ===== rtl/dled_fifo.sv =====
module dled_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dled_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            pop,
  output dled_pkg::cmd_t  rdata,
  output logic            empty
);
  import dled_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/dled_front.sv =====
module dled_front (
  input  logic            clk,
  input  logic            rst_n,
  input  dled_pkg::cfg_t  cfg,
  input  logic            in_push,
  input  dled_pkg::in_t   in_data,
  output logic            in_full,
  output logic            q_push,
  output dled_pkg::cmd_t  q_wdata,
  input  logic            q_full
);
  import dled_pkg::*;

  bal_t               bal_r, bal_nxt;
  logic signed [31:0] meas_r, meas_nxt;
  logic               accept;
  logic signed [33:0] m2, s2, r2, lo, hi;
  bal_t               cls;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Classify against the band at double scale
  always_comb begin
    m2 = {in_data.measured_value[31], in_data.measured_value, 1'b0};
    s2 = {cfg.setpoint[31], cfg.setpoint, 1'b0};
    r2 = $signed({3'b000, cfg.target_range});
    lo = s2 - r2;
    hi = s2 + r2;
    if (m2 > lo && m2 < hi) begin
      cls = ST_BAL;
    end else if (in_data.measured_value > cfg.setpoint) begin
      cls = ST_HIGH;
    end else begin
      cls = ST_LOW;
    end
  end

  // Update state and hand work to the back end
  always_comb begin
    bal_nxt       = bal_r;
    meas_nxt      = meas_r;
    q_push        = 1'b0;
    q_wdata.kind  = KIND_STATE;
    q_wdata.state = cls;
    q_wdata.meas  = meas_r;
    if (accept) begin
      if (in_data.op == OP_MEAS) begin
        meas_nxt = in_data.measured_value;
        if (cfg.enabled) begin
          bal_nxt = cls;
          q_push  = (cls != bal_r);
        end
      end else begin
        q_wdata.kind  = KIND_DRIVE;
        q_wdata.state = bal_r;
        q_push        = cfg.enabled && (bal_r == ST_LOW || bal_r == ST_HIGH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r  <= ST_UNDEF;
      meas_r <= '0;
    end else begin
      bal_r  <= bal_nxt;
      meas_r <= meas_nxt;
    end
  end

endmodule

// ===== rtl/dled_back.sv =====
module dled_back (
  input  logic            clk,
  input  logic            rst_n,
  input  dled_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  dled_pkg::cmd_t  q_rdata,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output dled_pkg::out_t  out_data
);
  import dled_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIFF = 7'b0000010,
    S_MAG  = 7'b0000100,
    S_OFF  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } st_t;

  st_t                st_r, st_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic [32:0]        x_r, x_nxt;
  logic signed [33:0] diff_r, diff_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [30:0]        rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  out_t               out_r, out_nxt;
  logic               oval_r, oval_nxt;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_sel;
  logic [31:0]        rem_sh;
  logic               ge;
  logic [RATE_W-1:0]  rate;
  logic [31:0]        prod;
  logic               is_last;

  assign out_empty = !oval_r;
  assign out_data  = out_r;
  assign out_free  = !oval_r || out_pop;
  assign q_pop     = (st_r == S_IDLE) && !q_empty;

  // Count and rate of the direction in use
  always_comb begin
    if (q_rdata.state == ST_HIGH) begin
      cnt_sel = sat_count(cfg.actuator_counts[5:3]);
    end else begin
      cnt_sel = sat_count(cfg.actuator_counts[2:0]);
    end
    if (cmd_r.state == ST_HIGH) begin
      rate = cfg.decrease_rates[{slot_r, 4'b0000} +: RATE_W];
    end else begin
      rate = cfg.increase_rates[{slot_r, 4'b0000} +: RATE_W];
    end
    prod    = frac_r * rate;
    is_last = (CNT_W'(slot_r) + 1'b1) == cnt_r;
    rem_sh  = {rem_r, 1'b0};
    ge      = rem_sh >= {1'b0, cfg.edge_length};
  end

  // Sequence one command
  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    d_nxt    = d_r;
    x_nxt    = x_r;
    diff_nxt = diff_r;
    frac_nxt = frac_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    out_nxt  = out_r;
    oval_nxt = oval_r && !out_pop;
    case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          cmd_nxt  = q_rdata;
          cnt_nxt  = cnt_sel;
          slot_nxt = '0;
          if (q_rdata.kind == KIND_STATE) begin
            st_nxt = S_EMIT;
          end else if (cnt_sel != '0) begin
            st_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        d_nxt  = $signed({cmd_r.meas[31], cmd_r.meas}) -
                 $signed({cfg.setpoint[31], cfg.setpoint});
        st_nxt = S_MAG;
      end
      S_MAG: begin
        x_nxt  = d_r[32] ? 33'(-d_r) : 33'(d_r);
        st_nxt = S_OFF;
      end
      S_OFF: begin
        diff_nxt = $signed({1'b0, x_r}) - $signed({3'b000, cfg.edge_offset});
        st_nxt   = S_CMP;
      end
      S_CMP: begin
        // Step edge, below the edge, beyond the edge, or divide
        if (cfg.edge_length == '0) begin
          frac_nxt = diff_r[33] ? '0 : Q15_ONE;
          st_nxt   = S_EMIT;
        end else if (diff_r[33] || diff_r == '0) begin
          frac_nxt = '0;
          st_nxt   = S_EMIT;
        end else if (diff_r[32:0] >= {2'b00, cfg.edge_length}) begin
          frac_nxt = Q15_ONE;
          st_nxt   = S_EMIT;
        end else begin
          rem_nxt  = diff_r[30:0];
          q_nxt    = '0;
          step_nxt = '0;
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? 31'(rem_sh - {1'b0, cfg.edge_length}) : rem_sh[30:0];
        q_nxt    = {q_r[DIV_STEPS-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          frac_nxt = {1'b0, q_nxt};
          st_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          oval_nxt              = 1'b1;
          out_nxt.balance_state = cmd_r.state;
          if (cmd_r.kind == KIND_STATE) begin
            out_nxt.kind          = KIND_STATE;
            out_nxt.actuator_slot = '0;
            out_nxt.direction     = DIR_INC;
            out_nxt.drive_level   = '0;
            out_nxt.last          = 1'b1;
            st_nxt                = S_IDLE;
          end else begin
            out_nxt.kind          = KIND_DRIVE;
            out_nxt.actuator_slot = slot_r;
            out_nxt.direction     = (cmd_r.state == ST_HIGH) ? DIR_DEC : DIR_INC;
            out_nxt.drive_level   = prod[30:15];
            out_nxt.last          = is_last;
            slot_nxt              = slot_r + 1'b1;
            if (is_last) begin
              st_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      oval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Hold work and result payload
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    d_r    <= d_nxt;
    x_r    <= x_nxt;
    diff_r <= diff_nxt;
    frac_r <= frac_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    slot_r <= slot_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && cmd_r.kind == KIND_DRIVE) |-> (CNT_W'(slot_r) < cnt_r))
    else $error("drive slot beyond actuator count");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && cmd_r.kind == KIND_DRIVE) |-> (frac_r <= Q15_ONE))
    else $error("edge fraction above full scale");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> ({1'b0, rem_r} < {1'b0, cfg.edge_length}))
    else $error("divider remainder not below edge length");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV && step_r == STEP_W'(DIV_STEPS - 1)) |=> (st_r == S_EMIT))
    else $error("divider did not finish into emit");
`endif

endmodule

// ===== rtl/deadband_linear_edge_drive_top.sv =====
// Deadband balancer with a linear-edge drive. The front end takes a measurement
// word, stores the value, classifies it against the band round the setpoint
// and, while enabled, queues a state-change word when the state moves. A tick
// word in a driving state goes to the back end, which finds the edge fraction
// with its 15-step shift-subtract divider when the value lies on the ramp and
// skips the divider when it lies off the ramp or the edge is a step; each
// actuator slot costs one Q1.15 multiply. A tick with no actuators yields no
// result. A two-entry command queue sits between front and back, and a result
// register holds the oldest result until popped. The configuration port is
// always ready and must be written only while the block is idle.
module deadband_linear_edge_drive_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  dled_pkg::in_t                       in_data,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output dled_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dled_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_data
);
  import dled_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Decode configuration writes, drop unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SETPOINT:     cfg_nxt.setpoint        = $signed(cfg_data[31:0]);
        CFG_TARGET_RANGE: cfg_nxt.target_range    = cfg_data[30:0];
        CFG_EDGE_OFFSET:  cfg_nxt.edge_offset     = cfg_data[30:0];
        CFG_EDGE_LENGTH:  cfg_nxt.edge_length     = cfg_data[30:0];
        CFG_ENABLED:      cfg_nxt.enabled         = cfg_data[0];
        CFG_INC_RATES:    cfg_nxt.increase_rates  = cfg_data;
        CFG_DEC_RATES:    cfg_nxt.decrease_rates  = cfg_data;
        CFG_ACT_COUNTS:   cfg_nxt.actuator_counts = cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dled_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  dled_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dled_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dled_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'hF;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  in_t                  in_data;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  deadband_linear_edge_drive_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers and state
  cfg_t               shadow_cfg;
  bal_t               shadow_state;
  logic signed [31:0] shadow_meas;
  out_t               due_reports[$];

  int          errors;
  int unsigned cycle_count;
  int          hold_len;
  bit          idle_on;
  logic [31:0] meas_span;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Apply one register write to the shadow copy
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_SETPOINT:     shadow_cfg.setpoint        = val[31:0];
      CFG_TARGET_RANGE: shadow_cfg.target_range    = val[30:0];
      CFG_EDGE_OFFSET:  shadow_cfg.edge_offset     = val[30:0];
      CFG_EDGE_LENGTH:  shadow_cfg.edge_length     = val[30:0];
      CFG_ENABLED:      shadow_cfg.enabled         = val[0];
      CFG_INC_RATES:    shadow_cfg.increase_rates  = val;
      CFG_DEC_RATES:    shadow_cfg.decrease_rates  = val;
      CFG_ACT_COUNTS:   shadow_cfg.actuator_counts = val[5:0];
      default: ;
    endcase
  endfunction

  // Q1.15 position of the stored measurement on the linear edge
  function automatic logic [15:0] edge_frac();
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [32:0]        over;
    logic [47:0]        num;
    diff = $signed({shadow_meas[31], shadow_meas}) -
           $signed({shadow_cfg.setpoint[31], shadow_cfg.setpoint});
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    if (shadow_cfg.edge_length == '0)
      return (mag >= 33'(shadow_cfg.edge_offset)) ? Q15_ONE : 16'h0000;
    if (mag <= 33'(shadow_cfg.edge_offset))
      return 16'h0000;
    over = mag - 33'(shadow_cfg.edge_offset);
    if (over >= 33'(shadow_cfg.edge_length))
      return Q15_ONE;
    num = {over, 15'b0};
    return 16'(num / 48'(shadow_cfg.edge_length));
  endfunction

  // Classify a measurement or compute drive levels for a tick
  function automatic void balance_and_drive(input in_t w);
    bal_t               prev;
    logic signed [33:0] m2;
    logic signed [33:0] s2;
    logic signed [33:0] band;
    logic [15:0]        frac;
    logic [15:0]        rate;
    logic [31:0]        prod;
    logic [63:0]        rates;
    logic [2:0]         cnt;
    logic               dir;
    out_t               r;
    if (w.op == OP_MEAS) begin
      prev = shadow_state;
      shadow_meas = w.measured_value;
      if (!shadow_cfg.enabled)
        return;
      m2   = {w.measured_value[31], w.measured_value, 1'b0};
      s2   = {shadow_cfg.setpoint[31], shadow_cfg.setpoint, 1'b0};
      band = {3'b000, shadow_cfg.target_range};
      if (m2 > s2 - band && m2 < s2 + band)
        shadow_state = ST_BAL;
      else if ($signed(w.measured_value) > $signed(shadow_cfg.setpoint))
        shadow_state = ST_HIGH;
      else
        shadow_state = ST_LOW;
      if (shadow_state != prev) begin
        r = '0;
        r.kind = KIND_STATE;
        r.balance_state = shadow_state;
        r.last = 1'b1;
        due_reports.insert(due_reports.size(), r);
      end
    end else if (shadow_cfg.enabled && (shadow_state == ST_LOW || shadow_state == ST_HIGH)) begin
      frac  = edge_frac();
      dir   = (shadow_state == ST_HIGH) ? DIR_DEC : DIR_INC;
      rates = (dir == DIR_DEC) ? shadow_cfg.decrease_rates : shadow_cfg.increase_rates;
      cnt   = (dir == DIR_DEC) ? shadow_cfg.actuator_counts[5:3] :
                                 shadow_cfg.actuator_counts[2:0];
      if (cnt > 3'(MAX_ACTUATORS))
        cnt = 3'(MAX_ACTUATORS);
      for (int i = 0; i < int'(cnt); i++) begin
        rate = rates[16*i +: 16];
        prod = 32'(frac) * 32'(rate);
        r = '0;
        r.kind = KIND_DRIVE;
        r.balance_state = shadow_state;
        r.actuator_slot = SLOT_W'(i);
        r.direction = dir;
        r.drive_level = prod[30:15];
        r.last = (i == int'(cnt) - 1);
        due_reports.insert(due_reports.size(), r);
      end
    end
  endfunction

  function automatic in_t meas_word(input logic [31:0] v);
    in_t w;
    w.op = OP_MEAS;
    w.measured_value = v;
    return w;
  endfunction

  function automatic in_t tick_word();
    in_t w;
    w.op = OP_TICK;
    w.measured_value = $urandom;
    return w;
  endfunction

  // Mostly values around the setpoint, sometimes anywhere
  function automatic in_t random_word();
    in_t         w;
    logic [31:0] dv;
    w.op = ($urandom_range(0, 9) < 4) ? OP_MEAS : OP_TICK;
    if ($urandom_range(0, 7) == 0) begin
      w.measured_value = $urandom;
    end else begin
      dv = 32'($urandom) & {meas_span[30:0], 1'b1};
      if ($urandom_range(0, 1) == 1)
        dv = -dv;
      w.measured_value = shadow_cfg.setpoint + dv;
    end
    return w;
  endfunction

  // Offer one word, with an occasional gap before it
  task automatic send_word(input in_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_push = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_full);
    balance_and_drive(w);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop the input, wait for every due result, then let the back end finish
  task automatic settle();
    in_push = 1'b0;
    while (due_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result receiver with random stalls and an optional long hold
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_pop = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_pop = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_pop = 1'b1;
    end
  end

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Compare each popped word with the oldest due one
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
      end else begin
        want = due_reports.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("balance_state", want.balance_state, out_data.balance_state);
        check_field("actuator_slot", want.actuator_slot, out_data.actuator_slot);
        check_field("direction", want.direction, out_data.direction);
        check_field("drive_level", want.drive_level, out_data.drive_level);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // Disabled block stays silent; unknown index is ignored
  task automatic test_disabled();
    write_reg(CFG_NO_REG, '1);
    send_word(meas_word(32'h7FFF_FFFF));
    send_word(tick_word());
    settle();
  endtask

  // Band edges are exclusive, plus value and setpoint extremes
  task automatic test_classify();
    write_reg(CFG_SETPOINT, 64'h0001_0000);
    write_reg(CFG_TARGET_RANGE, 64'h0002_0000);
    write_reg(CFG_ENABLED, 64'd1);
    send_word(meas_word(32'h0000_0000));
    send_word(meas_word(32'h0002_0000));
    send_word(meas_word(32'h0000_0001));
    send_word(meas_word(32'h8000_0000));
    send_word(meas_word(32'h7FFF_FFFF));
    settle();
    // Empty band: value on the setpoint reads low
    write_reg(CFG_TARGET_RANGE, 64'd0);
    send_word(meas_word(32'h0001_0000));
    settle();
    write_reg(CFG_SETPOINT, 64'hFFFF_FFFF_8000_0000);
    write_reg(CFG_TARGET_RANGE, 64'h7FFF_FFFF);
    send_word(meas_word(32'h8000_0000));
    send_word(meas_word(32'h7FFF_FFFF));
    settle();
    // Stored while disabled, classified state kept
    write_reg(CFG_ENABLED, 64'd0);
    send_word(meas_word(32'h0000_0000));
    settle();
    write_reg(CFG_ENABLED, 64'd1);
    send_word(tick_word());
    settle();
  endtask

  // Step and ramp edges, saturated counts, zero actuators, balanced tick
  task automatic test_edge_drive();
    write_reg(CFG_SETPOINT, 64'd0);
    write_reg(CFG_TARGET_RANGE, 64'd2);
    write_reg(CFG_EDGE_OFFSET, 64'h100);
    write_reg(CFG_EDGE_LENGTH, 64'd0);
    write_reg(CFG_INC_RATES, 64'hFFFF_8000_4000_0001);
    write_reg(CFG_DEC_RATES, 64'h8001_7FFF_0000_FFFF);
    write_reg(CFG_ACT_COUNTS, {58'd0, 3'd7, 3'd3});
    send_word(meas_word(32'hFFFF_FF00));
    send_word(tick_word());
    send_word(meas_word(32'hFFFF_FF01));
    send_word(tick_word());
    send_word(meas_word(32'h7FFF_FFFF));
    send_word(tick_word());
    send_word(meas_word(32'h0000_0000));
    send_word(tick_word());
    settle();
    write_reg(CFG_EDGE_LENGTH, 64'h1000);
    send_word(meas_word(32'h0000_0900));
    send_word(tick_word());
    send_word(meas_word(32'h0000_1100));
    send_word(tick_word());
    settle();
    write_reg(CFG_SETPOINT, 64'h7FFF_FFFF);
    write_reg(CFG_ACT_COUNTS, 64'd0);
    send_word(meas_word(32'h8000_0000));
    send_word(tick_word());
    settle();
    write_reg(CFG_ACT_COUNTS, {58'd0, 3'd4, 3'd4});
    send_word(tick_word());
    settle();
  endtask

  // Hold the receiver off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(CFG_SETPOINT, 64'd0);
    write_reg(CFG_EDGE_OFFSET, 64'd0);
    write_reg(CFG_EDGE_LENGTH, 64'h4000_0000);
    write_reg(CFG_INC_RATES, {$urandom, $urandom});
    write_reg(CFG_DEC_RATES, {$urandom, $urandom});
    write_reg(CFG_ACT_COUNTS, {58'd0, 3'd4, 3'd4});
    send_word(meas_word(32'h3000_0000));
    hold_len = HOLD_CYCLES;
    repeat (30) send_word(tick_word());
    settle();
  endtask

  // New random register set; scales chosen so that band, edge and values meet
  task automatic randomize_setup();
    logic [31:0] mask;
    logic [63:0] len;
    mask = (32'd1 << $urandom_range(2, 31)) - 1;
    meas_span = mask;
    len = ($urandom_range(0, 4) == 0) ? 64'd0 :
          {32'($urandom), (32'($urandom) & mask) | (32'($urandom) & 32'h8000_0000)};
    write_reg(CFG_SETPOINT, {$urandom, $urandom});
    write_reg(CFG_TARGET_RANGE,
              {32'($urandom), (32'($urandom) & mask) | (32'($urandom) & 32'h8000_0000)});
    write_reg(CFG_EDGE_OFFSET,
              {32'($urandom), (32'($urandom) & (mask >> 1)) | (32'($urandom) & 32'h8000_0000)});
    write_reg(CFG_EDGE_LENGTH, len);
    write_reg(CFG_ENABLED, {32'($urandom), 31'($urandom), $urandom_range(0, 5) != 0});
    write_reg(CFG_INC_RATES, {$urandom, $urandom});
    write_reg(CFG_DEC_RATES, {$urandom, $urandom});
    write_reg(CFG_ACT_COUNTS, {$urandom, $urandom});
    // Now and then write an index with no register behind it
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_ACT_COUNTS + 4'($urandom_range(1, 8)), {$urandom, $urandom});
  endtask

  task automatic test_random(input int phases, input int per_phase);
    repeat (phases) begin
      settle();
      randomize_setup();
      repeat (per_phase) send_word(random_word());
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors      = 0;
    cycle_count = 0;
    hold_len    = 0;
    idle_on     = 1'b1;
    meas_span   = 32'hFFFF;
    shadow_cfg   = '0;
    shadow_state = ST_UNDEF;
    shadow_meas  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_disabled();
    test_classify();
    test_edge_drive();
    test_backpressure();
    test_random(8, 36);
    // Last stretch runs with both sides at full rate
    idle_on = 1'b0;
    test_random(2, 25);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
